// ===== hw/rtl/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// Thread scheduler package
// Shared constants and types of the FIFO thread scheduler with join.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam int unsigned MaxThreads = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SPAWN = 2'd1,
    OP_DONE  = 2'd2,
    OP_JOIN  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOTFOUND = 2'd1,
    STS_DEADLOCK = 2'd2,
    STS_NOSLOT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SL_FREE       = 3'd0,
    SL_READY      = 3'd1,
    SL_RUNNING    = 3'd2,
    SL_WAITING    = 3'd3,
    SL_TERMINATED = 3'd4
  } slot_e;

endpackage

// ===== hw/rtl/fts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module fts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/fifo_thread_scheduler_with_join_top.sv =====
// ----------------------------------------------------------------------------
// FIFO thread scheduler with join
// Event-driven thread scheduler with a ready queue and per-thread joiner lists.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata = {target_tid, op}
// m_axis    out        tdata = {halted, running_tid, result_tid, status}
//
// One event at a time. From the input transfer to a valid result: tick and a
// join that blocks pass through S_SW, S_POP and S_POPD to S_OUT; a failed join,
// a join on a terminated target or any event after halt goes straight to S_OUT;
// spawn scans slot states in S_SPAWN, one slot state per cycle, up to the first
// free slot (through the last slot with no free slot); done walks its joiners
// serially through the link memory in S_WAKE and S_WLINK, then goes on as a
// tick. The input is ready again the cycle after the result register is loaded;
// a stalled result holds the next event in S_OUT. Slot states, list heads and
// flags reset with rst_ni; queue and link entries are memories without reset.
module fifo_thread_scheduler_with_join_top
  import fts_pkg::*;
#(
  parameter int unsigned MaxThr = MaxThreads
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [1:0] op, [5:2] target_tid
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [15:0] m_axis_tdata   // [1:0] status, [5:2] result_tid,
                                     // [9:6] running_tid, [10] halted
);

  localparam int unsigned Aw = $clog2(MaxThr);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SPAWN = 8'b00000010,
    S_WAKE  = 8'b00000100,
    S_WLINK = 8'b00001000,
    S_SW    = 8'b00010000,
    S_POP   = 8'b00100000,
    S_POPD  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  slot_e        slot_q [MaxThr];
  logic         jnil_q [MaxThr];
  logic [Aw-1:0] jhead_q [MaxThr];
  logic [Aw-1:0] head_q, tail_q, run_q, ret_q, w_q, scan_q;
  logic [Aw:0]  cnt_q;
  logic         ret_v_q, halt_q, wv_q;
  logic [1:0]   sts_q;
  logic [3:0]   res_q;
  logic         ovalid_q;
  logic [15:0]  odata_q;

  // Per-entry flag: the link of this thread points to a real joiner.
  logic lv_q [MaxThr];
  function automatic logic lnk_v(logic [Aw-1:0] a);
    return lv_q[a];
  endfunction

  // queue memory
  logic         q_we;
  logic [Aw-1:0] q_waddr, q_wdata, q_rdata;
  // link memory
  logic         l_we;
  logic [Aw-1:0] l_waddr, l_wdata, l_rdata;

  fts_ram #(.Width(Aw), .Depth(MaxThr)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(head_q), .rdata_o(q_rdata));
  fts_ram #(.Width(Aw), .Depth(MaxThr)) u_link (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(w_q), .rdata_o(l_rdata));

  logic [1:0] in_op;
  logic [3:0] in_tgt;
  logic       tgt_ok;
  logic [Aw-1:0] tgt;
  assign in_op  = s_axis_tdata[1:0];
  assign in_tgt = s_axis_tdata[5:2];
  assign tgt    = Aw'(in_tgt);
  assign tgt_ok = (32'(in_tgt) < MaxThr);

  // The result register can take a new result when it is empty or drains now.
  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // Queue pushes happen in SPAWN, WAKE or SW; the head advances only in POPD.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail_q;
    q_wdata = '0;
    l_we    = 1'b0;
    l_waddr = run_q;
    l_wdata = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc && !halt_q) begin
          unique case (op_e'(in_op))
            OP_TICK:  state_d = S_SW;
            OP_SPAWN: state_d = S_SPAWN;
            OP_DONE:  state_d = S_WAKE;
            OP_JOIN: begin
              if (tgt_ok && slot_q[tgt] != SL_FREE && cnt_q != '0
                  && slot_q[tgt] != SL_TERMINATED) begin
                l_we    = 1'b1;
                l_wdata = jhead_q[tgt];
                state_d = S_SW;
              end else begin
                state_d = S_OUT;
              end
            end
            default: state_d = S_OUT;
          endcase
        end else if (acc) begin
          state_d = S_OUT;
        end
      end
      S_SPAWN: begin
        if (slot_q[scan_q] == SL_FREE) begin
          q_we    = 1'b1;
          q_wdata = scan_q;
          state_d = S_OUT;
        end else if (32'(scan_q) == MaxThr - 1) begin
          state_d = S_OUT;
        end
      end
      S_WAKE: begin
        if (!wv_q) begin
          state_d = S_SW;
        end else begin
          q_we    = 1'b1;
          q_wdata = w_q;
          state_d = S_WLINK;
        end
      end
      S_WLINK: state_d = S_WAKE;
      S_SW: begin
        if (slot_q[run_q] == SL_RUNNING) begin
          q_we    = 1'b1;
          q_wdata = run_q;
        end
        state_d = S_POP;
      end
      S_POP:  state_d = S_POPD;
      S_POPD: state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      for (int i = 0; i < MaxThr; i++) begin
        slot_q[i]  <= (i == 0) ? SL_RUNNING : SL_FREE;
        jnil_q[i]  <= 1'b1;
        jhead_q[i] <= '0;
      end
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      run_q    <= '0;
      ret_q    <= '0;
      w_q      <= '0;
      ret_v_q  <= 1'b0;
      halt_q   <= 1'b0;
      ovalid_q <= 1'b0;
      wv_q     <= 1'b0;
      scan_q   <= '0;
      sts_q    <= STS_OK;
      res_q    <= '0;
      odata_q  <= '0;
    end else begin
      state_q <= state_d;
      if (q_we) begin
        tail_q <= (32'(tail_q) == MaxThr - 1) ? '0 : tail_q + 1'b1;
        cnt_q  <= cnt_q + 1'b1;
      end
      if (state_q == S_OUT && out_free) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          sts_q  <= STS_OK;
          res_q  <= '0;
          scan_q <= '0;
          if (acc && !halt_q) begin
            unique case (op_e'(in_op))
              OP_DONE: begin
                slot_q[run_q] <= SL_TERMINATED;
                w_q  <= jhead_q[run_q];
                wv_q <= !jnil_q[run_q];
                jnil_q[run_q] <= 1'b1;
              end
              OP_JOIN: begin
                if (!tgt_ok || slot_q[tgt] == SL_FREE) begin
                  sts_q <= STS_NOTFOUND;
                end else if (cnt_q == '0) begin
                  sts_q <= STS_DEADLOCK;
                end else begin
                  res_q <= in_tgt;
                  if (slot_q[tgt] != SL_TERMINATED) begin
                    slot_q[run_q]  <= SL_WAITING;
                    jhead_q[tgt]   <= run_q;
                    jnil_q[tgt]    <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_SPAWN: begin
          if (slot_q[scan_q] == SL_FREE) begin
            slot_q[scan_q] <= SL_READY;
            jnil_q[scan_q] <= 1'b1;
            res_q <= 4'(scan_q);
          end else if (32'(scan_q) == MaxThr - 1) begin
            sts_q <= STS_NOSLOT;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_WAKE: begin
          if (wv_q) slot_q[w_q] <= SL_READY;
        end
        S_WLINK: begin
          // The link read of w_q returns now; the walk ends when the woken
          // thread had no joiner behind it in the list.
          w_q  <= l_rdata;
          wv_q <= (l_rdata != w_q) && lnk_v(w_q);
        end
        S_SW: begin
          if (slot_q[run_q] == SL_RUNNING) begin
            slot_q[run_q] <= SL_READY;
          end else if (slot_q[run_q] == SL_TERMINATED) begin
            if (ret_v_q) slot_q[ret_q] <= SL_FREE;
            if (run_q == '0) begin
              slot_q[0] <= SL_FREE;
              ret_v_q   <= 1'b0;
            end else begin
              ret_q   <= run_q;
              ret_v_q <= 1'b1;
            end
          end
        end
        S_POP: begin
          if (cnt_q == '0) halt_q <= 1'b1;
        end
        S_POPD: begin
          if (!halt_q) begin
            slot_q[q_rdata] <= SL_RUNNING;
            run_q  <= q_rdata;
            head_q <= (32'(head_q) == MaxThr - 1) ? '0 : head_q + 1'b1;
            cnt_q  <= cnt_q - 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            odata_q <= {5'd0, halt_q, 4'(run_q), res_q, sts_q};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxThr; i++) lv_q[i] <= 1'b0;
    end else if (l_we) begin
      lv_q[run_q] <= !jnil_q[tgt];
    end
  end

endmodule

// ===== hw/rtl/fts_checker.sv =====
// ----------------------------------------------------------------------------
// Scheduler port checker
// Port-level properties of the thread scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module fts_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Once halted, the flag stays set in every later result.
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |=> !m_axis_tvalid || m_axis_tdata[10])
    else $error("halted flag cleared");

  // Events are taken one at a time: an input transfer drops ready.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // Reserved data bits stay zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:11] == 5'd0)
    else $error("padding bits set");

endmodule

bind fifo_thread_scheduler_with_join_top fts_port_checker u_fts_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
